// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is asserted
`define FFHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked in the following cycle
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ffha_pkg.sv
`default_nettype none

package ffha_pkg;

	localparam int HOLES     = 16;
	localparam int SIZE_BITS = 16;
	localparam int IDX_BITS  = (HOLES > 1) ? $clog2(HOLES) : 1;
	localparam int CNT_BITS  = $clog2(HOLES + 1);

	typedef logic [SIZE_BITS-1:0] size_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN
	} state_t;

	typedef struct packed {
		size_t loaded_size;
		size_t free_size;
	} entry_t;

	typedef struct packed {
		logic   en;
		idx_t   addr;
		entry_t data;
	} wr_req_t;

endpackage

`default_nettype wire

// File: rtl/first_fit_hole_allocator.sv
// channel   | signals                                          | transfer
// ----------+--------------------------------------------------+-----------------------
// command   | start, busy, operation, hole_index, amount       | start high, busy low
// result    | done, granted, chosen_hole, remaining_size,      | done high, one cycle
//           | original_size                                    |
// config    | cfg_we, cfg_wdata (hole_count)                   | cfg_we high
//
// load, unused code and out-of-range read: result in the cycle after the transfer, no busy
// read: one table read; the entry is registered in the table, then in the result registers
// allocate: table scanned one entry per cycle, busy during the scan
// allocate: result in the cycle busy falls
// reset clears control state and hole_count; table contents undefined until loaded
// the receiver cannot stall: each result sits on the ports for exactly one cycle
`default_nettype none

`include "assert_macros.svh"

module first_fit_hole_allocator (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire [1:0]  operation,
	input  wire [3:0]  hole_index,
	input  wire [15:0] amount,
	input  wire        cfg_we,
	input  wire [4:0]  cfg_wdata,
	output logic       done,
	output logic       granted,
	output logic [3:0] chosen_hole,
	output logic [15:0] remaining_size,
	output logic [15:0] original_size
);
	import ffha_pkg::*;

	state_t  state_q, state_d;
	cnt_t    hole_count_q;
	cnt_t    ptr_q, ptr_d;
	logic    vld_s1, vld_d;
	idx_t    addr_s1, addr_d;
	idx_t    idx_q, idx_d;
	size_t   amt_q, amt_d;

	logic        done_q, done_d;
	logic        granted_q, granted_d;
	logic [3:0]  chosen_q, chosen_d;
	size_t       rem_q, rem_d;
	size_t       orig_q, orig_d;

	wr_req_t wr;
	idx_t    raddr;
	entry_t  rdata;
	logic    idx_ok;
	logic    fit;
	logic    issue;
	size_t   amt_in;
	size_t   new_free;

	ffha_table u_table (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign amt_in   = SIZE_BITS'(amount);
	assign idx_ok   = (32'(hole_index) < HOLES);
	assign fit      = vld_s1 && (amt_q <= rdata.free_size);
	assign issue    = (ptr_q < hole_count_q);
	assign new_free = rdata.free_size - amt_q;

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		vld_d     = vld_s1;
		addr_d    = addr_s1;
		idx_d     = idx_q;
		amt_d     = amt_q;
		done_d    = 1'b0;
		granted_d = granted_q;
		chosen_d  = chosen_q;
		rem_d     = rem_q;
		orig_d    = orig_q;
		wr        = '0;
		raddr     = (state_q == ST_SCAN) ? IDX_BITS'(ptr_q) : IDX_BITS'(hole_index);

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					idx_d = IDX_BITS'(hole_index);
					amt_d = amt_in;
					case (op_t'(operation))
						OP_LOAD: begin
							wr.en     = idx_ok;
							wr.addr   = IDX_BITS'(hole_index);
							wr.data   = '{loaded_size: amt_in, free_size: amt_in};
							done_d    = 1'b1;
							granted_d = 1'b0;
							chosen_d  = hole_index;
							rem_d     = amt_in;
							orig_d    = amt_in;
						end
						OP_ALLOC: begin
							ptr_d   = '0;
							vld_d   = 1'b0;
							state_d = ST_SCAN;
						end
						OP_READ: begin
							if (idx_ok) begin
								state_d = ST_READ;
							end else begin
								done_d    = 1'b1;
								granted_d = 1'b0;
								chosen_d  = '0;
								rem_d     = '0;
								orig_d    = '0;
							end
						end
						default: begin
							done_d    = 1'b1;
							granted_d = 1'b0;
							chosen_d  = '0;
							rem_d     = '0;
							orig_d    = '0;
						end
					endcase
				end
			end
			ST_READ: begin
				done_d    = 1'b1;
				granted_d = 1'b0;
				chosen_d  = 4'(idx_q);
				rem_d     = rdata.free_size;
				orig_d    = rdata.loaded_size;
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				if (fit) begin
					wr.en     = 1'b1;
					wr.addr   = addr_s1;
					wr.data   = '{loaded_size: rdata.loaded_size, free_size: new_free};
					done_d    = 1'b1;
					granted_d = 1'b1;
					chosen_d  = 4'(addr_s1);
					rem_d     = new_free;
					orig_d    = rdata.loaded_size;
					vld_d     = 1'b0;
					state_d   = ST_IDLE;
				end else if (!vld_s1 && !issue) begin
					done_d    = 1'b1;
					granted_d = 1'b0;
					chosen_d  = '0;
					rem_d     = '0;
					orig_d    = '0;
					state_d   = ST_IDLE;
				end else begin
					vld_d  = issue;
					addr_d = IDX_BITS'(ptr_q);
					if (issue) begin
						ptr_d = ptr_q + cnt_t'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_count_q <= '0;
			done_q       <= 1'b0;
			vld_s1       <= 1'b0;
			ptr_q        <= '0;
		end else begin
			if (cfg_we) begin
				hole_count_q <= (32'(cfg_wdata) > HOLES) ? CNT_BITS'(HOLES)
				                                         : CNT_BITS'(cfg_wdata);
			end
			done_q <= done_d;
			vld_s1 <= vld_d;
			ptr_q  <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= addr_d;
		idx_q     <= idx_d;
		amt_q     <= amt_d;
		granted_q <= granted_d;
		chosen_q  <= chosen_d;
		rem_q     <= rem_d;
		orig_q    <= orig_d;
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign granted        = granted_q;
	assign chosen_hole    = chosen_q;
	assign remaining_size = 16'(rem_q);
	assign original_size  = 16'(orig_q);

	// every transfer leads to a result or to a busy block
	`FFHA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_q, "transfer lost")

	// a grant names a hole inside the scanned range
	`FFHA_ASSERT(a_grant_in_range, (done_q && granted_q) |-> (5'(chosen_q) < 5'(hole_count_q)), "grant outside hole_count")

	// a table write during the scan is always the granted hole
	`FFHA_ASSERT_NEXT(a_scan_write_grants, (state_q == ST_SCAN) && wr.en, done_q && granted_q, "scan write without grant")

	// the scan never runs past the hole count
	`FFHA_ASSERT(a_ptr_bound, (state_q == ST_SCAN) |-> (ptr_q <= hole_count_q), "scan pointer overrun")

endmodule

`default_nettype wire

// File: rtl/ffha_table.sv
`default_nettype none

module ffha_table (
	input  wire                    clk,
	input  wire ffha_pkg::wr_req_t wr,
	input  wire ffha_pkg::idx_t    raddr,
	output ffha_pkg::entry_t       rdata
);
	import ffha_pkg::*;

	entry_t mem_q [HOLES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
